// ----- src/uartrq_pkg.sv -----
package uartrq_pkg;

    // Command codes carried on the command port.
    typedef enum logic [1:0] {
        CMD_RX_BYTE    = 2'd0,
        CMD_HOST_READ  = 2'd1,
        CMD_HOST_WRITE = 2'd2,
        CMD_TX_DONE    = 2'd3
    } cmd_t;

    // Actions that the controller asks of the datapath.
    typedef struct packed {
        logic load;
        logic rx_push;
        logic rx_drop;
        logic rx_pop;
        logic tx_push;
        logic tx_reject;
        logic send_direct;
        logic tx_pop;
        logic clr_busy;
        logic finish;
    } ctrl_t;

    // Ring and line status reported back by the datapath.
    typedef struct packed {
        logic rx_full;
        logic rx_empty;
        logic tx_full;
        logic tx_empty;
        logic line_busy;
    } stat_t;

endpackage

// ----- src/uartrq_ram.sv -----
module uartrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/uartrq_ctrl.sv -----
module uartrq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          command,
    input  uartrq_pkg::stat_t   stat,
    output uartrq_pkg::ctrl_t   ctl,
    output logic                busy,
    output logic                done
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    uartrq_pkg::cmd_t  cmd_reg;
    logic              done_reg;
    logic              accept;

    assign accept = start && (state_reg == ST_IDLE);

    // Decode the held command against the ring status during the execute cycle.
    always_comb
    begin
        ctl = '0;
        ctl.load = accept;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.finish = 1'b1;
                state_next = ST_IDLE;
                case (cmd_reg)
                    uartrq_pkg::CMD_RX_BYTE:
                    begin
                        ctl.rx_drop = stat.rx_full;
                        ctl.rx_push = !stat.rx_full;
                    end
                    uartrq_pkg::CMD_HOST_READ:
                    begin
                        ctl.rx_pop = !stat.rx_empty;
                    end
                    uartrq_pkg::CMD_HOST_WRITE:
                    begin
                        ctl.send_direct = !stat.line_busy;
                        ctl.tx_push     = stat.line_busy && !stat.tx_full;
                        ctl.tx_reject   = stat.line_busy && stat.tx_full;
                    end
                    uartrq_pkg::CMD_TX_DONE:
                    begin
                        ctl.tx_pop   = !stat.tx_empty;
                        ctl.clr_busy = stat.tx_empty;
                    end
                    default:
                    begin
                        ctl.finish = 1'b1;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, held command and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= uartrq_pkg::CMD_RX_BYTE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ctl.finish;
            if (accept)
            begin
                cmd_reg <= uartrq_pkg::cmd_t'(command);
            end
        end
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

    // The strobe always follows an execute cycle.
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_EXEC))
        else $error("result strobe without an execute cycle");

    // An accepted word is always executed in the following cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted word not executed");

    // At most one ring or line action is taken per command.
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.rx_push, ctl.rx_drop, ctl.rx_pop, ctl.tx_push,
                  ctl.tx_reject, ctl.send_direct, ctl.tx_pop, ctl.clr_busy}))
        else $error("several actions for one command");

endmodule

// ----- src/uartrq_dp.sv -----
module uartrq_dp #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  uartrq_pkg::ctrl_t   ctl,
    output uartrq_pkg::stat_t   stat,
    output logic [7:0]          read_byte,
    output logic                read_valid,
    output logic                send_start,
    output logic [7:0]          send_byte,
    output logic                line_sending,
    output logic [5:0]          rx_count,
    output logic                rx_dropped,
    output logic                tx_rejected
);

    localparam int RW = $clog2(RX_DEPTH);
    localparam int TW = $clog2(TX_DEPTH);
    localparam logic [RW-1:0] RX_LAST = RW'(RX_DEPTH - 1);
    localparam logic [TW-1:0] TX_LAST = TW'(TX_DEPTH - 1);

    logic [RW-1:0] rx_wr_reg;
    logic [RW-1:0] rx_rd_reg;
    logic [TW-1:0] tx_wr_reg;
    logic [TW-1:0] tx_rd_reg;
    logic          line_busy_reg;
    logic [RW-1:0] rx_wr_next;
    logic [RW-1:0] rx_rd_next;
    logic [TW-1:0] tx_wr_next;
    logic [TW-1:0] tx_rd_next;
    logic          line_busy_next;
    logic [RW-1:0] rx_wr_inc;
    logic [RW-1:0] rx_rd_inc;
    logic [TW-1:0] tx_wr_inc;
    logic [TW-1:0] tx_rd_inc;
    logic [7:0]    data_reg;
    logic [7:0]    rx_rdata;
    logic [7:0]    tx_rdata;
    logic [RW:0]   cnt_raw;
    logic [RW:0]   cnt;
    logic [RW+6:0] cnt_ext;

    logic [7:0]    read_byte_reg;
    logic          read_valid_reg;
    logic          send_start_reg;
    logic [7:0]    send_byte_reg;
    logic          line_sending_reg;
    logic [5:0]    rx_count_reg;
    logic          rx_dropped_reg;
    logic          tx_rejected_reg;

    // Ring storage; reads are issued as the word is accepted.
    uartrq_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .clk     (clk),
        .wr_en   (ctl.rx_push),
        .wr_addr (rx_wr_reg),
        .wr_data (data_reg),
        .rd_en   (ctl.load),
        .rd_addr (rx_rd_reg),
        .rd_data (rx_rdata)
    );

    uartrq_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .clk     (clk),
        .wr_en   (ctl.tx_push),
        .wr_addr (tx_wr_reg),
        .wr_data (data_reg),
        .rd_en   (ctl.load),
        .rd_addr (tx_rd_reg),
        .rd_data (tx_rdata)
    );

    // Wrapping increments of the four ring positions.
    assign rx_wr_inc = (rx_wr_reg == RX_LAST) ? '0 : rx_wr_reg + 1'b1;
    assign rx_rd_inc = (rx_rd_reg == RX_LAST) ? '0 : rx_rd_reg + 1'b1;
    assign tx_wr_inc = (tx_wr_reg == TX_LAST) ? '0 : tx_wr_reg + 1'b1;
    assign tx_rd_inc = (tx_rd_reg == TX_LAST) ? '0 : tx_rd_reg + 1'b1;

    // Status for the controller; one slot of each ring stays empty.
    always_comb
    begin
        stat.rx_full   = (rx_wr_inc == rx_rd_reg);
        stat.rx_empty  = (rx_wr_reg == rx_rd_reg);
        stat.tx_full   = (tx_wr_inc == tx_rd_reg);
        stat.tx_empty  = (tx_wr_reg == tx_rd_reg);
        stat.line_busy = line_busy_reg;
    end

    // Next positions and line flag.
    always_comb
    begin
        rx_wr_next = ctl.rx_push ? rx_wr_inc : rx_wr_reg;
        rx_rd_next = ctl.rx_pop  ? rx_rd_inc : rx_rd_reg;
        tx_wr_next = ctl.tx_push ? tx_wr_inc : tx_wr_reg;
        tx_rd_next = ctl.tx_pop  ? tx_rd_inc : tx_rd_reg;
        if (ctl.send_direct || ctl.tx_pop)
        begin
            line_busy_next = 1'b1;
        end
        else if (ctl.clr_busy)
        begin
            line_busy_next = 1'b0;
        end
        else
        begin
            line_busy_next = line_busy_reg;
        end
    end

    // Fill level of the receive ring after this command, cut to six bits.
    always_comb
    begin
        cnt_raw = {1'b0, rx_wr_next} - {1'b0, rx_rd_next};
        if (rx_wr_next >= rx_rd_next)
        begin
            cnt = cnt_raw;
        end
        else
        begin
            cnt = cnt_raw + (RW+1)'(RX_DEPTH);
        end
        cnt_ext = {6'b0, cnt};
    end

    // Ring positions and the line flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wr_reg     <= '0;
            rx_rd_reg     <= '0;
            tx_wr_reg     <= '0;
            tx_rd_reg     <= '0;
            line_busy_reg <= 1'b0;
        end
        else if (ctl.finish)
        begin
            rx_wr_reg     <= rx_wr_next;
            rx_rd_reg     <= rx_rd_next;
            tx_wr_reg     <= tx_wr_next;
            tx_rd_reg     <= tx_rd_next;
            line_busy_reg <= line_busy_next;
        end
    end

    // Held input byte and the result word.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            data_reg <= data_byte;
        end
        if (ctl.finish)
        begin
            read_byte_reg    <= ctl.rx_pop ? rx_rdata : 8'd0;
            read_valid_reg   <= ctl.rx_pop;
            send_start_reg   <= ctl.send_direct || ctl.tx_pop;
            send_byte_reg    <= ctl.send_direct ? data_reg :
                                (ctl.tx_pop ? tx_rdata : 8'd0);
            line_sending_reg <= line_busy_next;
            rx_count_reg     <= cnt_ext[5:0];
            rx_dropped_reg   <= ctl.rx_drop;
            tx_rejected_reg  <= ctl.tx_reject;
        end
    end

    assign read_byte    = read_byte_reg;
    assign read_valid   = read_valid_reg;
    assign send_start   = send_start_reg;
    assign send_byte    = send_byte_reg;
    assign line_sending = line_sending_reg;
    assign rx_count     = rx_count_reg;
    assign rx_dropped   = rx_dropped_reg;
    assign tx_rejected  = tx_rejected_reg;

    // Ring positions never leave the storage range.
    a_rx_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_wr_reg <= RX_LAST) && (rx_rd_reg <= RX_LAST))
        else $error("receive position out of range");

    a_tx_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_wr_reg <= TX_LAST) && (tx_rd_reg <= TX_LAST))
        else $error("transmit position out of range");

    // Starting a queued byte leaves the line marked busy.
    a_pop_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.tx_pop |=> line_busy_reg)
        else $error("line not busy after a queued byte started");

endmodule

// ----- src/uart_rx_tx_ring_queues.sv -----
// Order: the registered read of the ring RAMs is issued as a word is accepted; the
// pointer update, result registers and result strobe are loaded as the execute
// state ends, and while busy is high no new word is accepted.
// Reset: asynchronous and active low; both rings empty and the line idle at once.
// Ring contents are not cleared. The receiver cannot stall the result strobe.
module uart_rx_tx_ring_queues #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] command,
    input  logic [7:0] data_byte,
    output logic       done,
    output logic [7:0] read_byte,
    output logic       read_valid,
    output logic       send_start,
    output logic [7:0] send_byte,
    output logic       line_sending,
    output logic [5:0] rx_count,
    output logic       rx_dropped,
    output logic       tx_rejected
);

    uartrq_pkg::ctrl_t ctl;
    uartrq_pkg::stat_t stat;

    // Command sequencing.
    uartrq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy),
        .done    (done)
    );

    // Rings, line flag and result registers.
    uartrq_dp #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .ctl          (ctl),
        .stat         (stat),
        .read_byte    (read_byte),
        .read_valid   (read_valid),
        .send_start   (send_start),
        .send_byte    (send_byte),
        .line_sending (line_sending),
        .rx_count     (rx_count),
        .rx_dropped   (rx_dropped),
        .tx_rejected  (tx_rejected)
    );

endmodule

// ----- sim/tb_uart_rx_tx_ring_queues.sv -----
module tb_uart_rx_tx_ring_queues;

    localparam int RX_SLOTS    = 64;
    localparam int TX_SLOTS    = 32;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_WORDS = 430;
    localparam int PRINT_CAP   = 60;

    // One host-side word waiting to be driven, with an optional hold until the
    // block has delivered every outstanding result.
    typedef struct {
        uartrq_pkg::cmd_t op;
        logic [7:0]       payload;
        bit               hold;
    } host_word_t;

    // Everything the block reports for one word.
    typedef struct packed {
        logic [7:0] read_byte;
        logic       read_valid;
        logic       send_start;
        logic [7:0] send_byte;
        logic       line_sending;
        logic [5:0] rx_count;
        logic       rx_dropped;
        logic       tx_rejected;
    } port_status_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [1:0] command = uartrq_pkg::CMD_RX_BYTE;
    logic [7:0] data_byte = 8'h00;
    logic       busy;
    logic       done;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       send_start;
    logic [7:0] send_byte;
    logic       line_sending;
    logic [5:0] rx_count;
    logic       rx_dropped;
    logic       tx_rejected;

    host_word_t   pending_words[$];
    port_status_t awaited_status[$];
    int           outstanding = 0;
    int           quiet_cycles = 0;
    int           mismatches = 0;
    int           sender_idle_pct = 35;

    // Shadow copy of both rings and the line flag.
    logic [7:0] rx_ring[RX_SLOTS];
    logic [7:0] tx_ring[TX_SLOTS];
    int         rx_head = 0;
    int         rx_tail = 0;
    int         tx_head = 0;
    int         tx_tail = 0;
    logic       line_busy = 1'b0;

    uart_rx_tx_ring_queues dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .data_byte    (data_byte),
        .done         (done),
        .read_byte    (read_byte),
        .read_valid   (read_valid),
        .send_start   (send_start),
        .send_byte    (send_byte),
        .line_sending (line_sending),
        .rx_count     (rx_count),
        .rx_dropped   (rx_dropped),
        .tx_rejected  (tx_rejected)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Reset starts low and is released once, and is not asserted again.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what);
        begin
            if (mismatches < PRINT_CAP)
                $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        end
    endtask

    task automatic check_field(input string field, input int got, input int want);
        begin
            if (got != want)
                report_mismatch($sformatf("%s is 0x%0h, 0x%0h awaited", field, got, want));
        end
    endtask

    // Applies one word to the shadow rings and gives the status it must produce.
    task automatic advance_rings(input uartrq_pkg::cmd_t op, input logic [7:0] payload,
                                 output port_status_t status);
        int nxt;
        begin
            status = '0;
            case (op)
                uartrq_pkg::CMD_RX_BYTE:
                begin
                    nxt = (rx_head + 1) % RX_SLOTS;
                    if (nxt == rx_tail)
                        status.rx_dropped = 1'b1;
                    else
                    begin
                        rx_ring[rx_head] = payload;
                        rx_head = nxt;
                    end
                end
                uartrq_pkg::CMD_HOST_READ:
                begin
                    if (rx_tail != rx_head)
                    begin
                        status.read_byte  = rx_ring[rx_tail];
                        status.read_valid = 1'b1;
                        rx_tail = (rx_tail + 1) % RX_SLOTS;
                    end
                end
                uartrq_pkg::CMD_HOST_WRITE:
                begin
                    if (!line_busy)
                    begin
                        line_busy = 1'b1;
                        status.send_start = 1'b1;
                        status.send_byte  = payload;
                    end
                    else
                    begin
                        nxt = (tx_head + 1) % TX_SLOTS;
                        if (nxt == tx_tail)
                            status.tx_rejected = 1'b1;
                        else
                        begin
                            tx_ring[tx_head] = payload;
                            tx_head = nxt;
                        end
                    end
                end
                default:
                begin
                    // Transmitter finished: start the next queued byte or go idle.
                    if (tx_head != tx_tail)
                    begin
                        line_busy = 1'b1;
                        status.send_start = 1'b1;
                        status.send_byte  = tx_ring[tx_tail];
                        tx_tail = (tx_tail + 1) % TX_SLOTS;
                    end
                    else
                        line_busy = 1'b0;
                end
            endcase
            status.line_sending = line_busy;
            status.rx_count = 6'((RX_SLOTS + rx_head - rx_tail) % RX_SLOTS);
        end
    endtask

    // Driver: when the port is free, offer the next word unless idling or held.
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || !busy)
        begin
            if (pending_words.size() != 0
                && $urandom_range(0, 99) >= sender_idle_pct
                && (!pending_words[0].hold || (outstanding == 0 && !start)))
            begin
                start     <= 1'b1;
                command   <= pending_words[0].op;
                data_byte <= pending_words[0].payload;
                void'(pending_words.pop_front());
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check each result against the oldest prediction, then predict
    // for any word accepted at this edge.
    always @(posedge clk)
    begin
        port_status_t want;
        port_status_t fresh;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_status.size() == 0)
                    report_mismatch("result strobe with no word outstanding");
                else
                begin
                    want = awaited_status.pop_front();
                    check_field("read_byte", read_byte, want.read_byte);
                    check_field("read_valid", read_valid, want.read_valid);
                    check_field("send_start", send_start, want.send_start);
                    check_field("send_byte", send_byte, want.send_byte);
                    check_field("line_sending", line_sending, want.line_sending);
                    check_field("rx_count", rx_count, want.rx_count);
                    check_field("rx_dropped", rx_dropped, want.rx_dropped);
                    check_field("tx_rejected", tx_rejected, want.tx_rejected);
                end
            end
            if (start && !busy)
            begin
                advance_rings(uartrq_pkg::cmd_t'(command), data_byte, fresh);
                awaited_status.push_back(fresh);
            end
            outstanding  <= awaited_status.size();
            quiet_cycles <= ((start && !busy) || done) ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog on cycles with no traffic in either direction.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic add_word(input uartrq_pkg::cmd_t op, input logic [7:0] payload,
                            input bit hold);
        host_word_t w;
        begin
            w.op      = op;
            w.payload = payload;
            w.hold    = hold;
            pending_words.push_back(w);
        end
    endtask

    // A fill run followed by a drain run, as a host or line would produce it.
    task automatic add_burst(input uartrq_pkg::cmd_t fill_op, input uartrq_pkg::cmd_t drain_op,
                             input int fill_n, input int drain_n, input bit hold);
        begin
            for (int i = 0; i < fill_n; i++)
                add_word(fill_op, 8'($urandom), hold && i == 0);
            for (int i = 0; i < drain_n; i++)
                add_word(drain_op, 8'($urandom), 1'b0);
        end
    endtask

    // Stimulus, phase by phase, then the final verdict.
    initial
    begin
        int added;
        int kind;
        int idle_table[3];
        bit hold;
        idle_table[0] = 35;
        idle_table[1] = 74;
        idle_table[2] = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            @(negedge clk);
            sender_idle_pct = idle_table[phase];
            added = pending_words.size();
            if (phase == 0)
            begin
                // Empty-ring read and a transmit-done while the line is idle.
                add_word(uartrq_pkg::CMD_HOST_READ, 8'hFF, 1'b0);
                add_word(uartrq_pkg::CMD_TX_DONE, 8'hFF, 1'b0);
                // Extreme bytes through the receive ring, then one read too many.
                add_word(uartrq_pkg::CMD_RX_BYTE, 8'h00, 1'b0);
                add_word(uartrq_pkg::CMD_RX_BYTE, 8'hFF, 1'b0);
                add_word(uartrq_pkg::CMD_RX_BYTE, 8'hA5, 1'b0);
                repeat (4) add_word(uartrq_pkg::CMD_HOST_READ, 8'h00, 1'b0);
                // A write to an idle line goes straight out; the next ones queue.
                add_word(uartrq_pkg::CMD_HOST_WRITE, 8'hFF, 1'b0);
                add_word(uartrq_pkg::CMD_HOST_WRITE, 8'h00, 1'b0);
                add_word(uartrq_pkg::CMD_HOST_WRITE, 8'h5A, 1'b0);
                // Drain the transmit ring, then finish with the ring empty and idle.
                repeat (4) add_word(uartrq_pkg::CMD_TX_DONE, 8'h00, 1'b0);
                // Both rings filled past full so that drops and rejects occur.
                add_burst(uartrq_pkg::CMD_RX_BYTE, uartrq_pkg::CMD_HOST_READ,
                          RX_SLOTS + 2, RX_SLOTS + 1, 1'b0);
                add_word(uartrq_pkg::CMD_HOST_WRITE, 8'h3C, 1'b0);
                add_burst(uartrq_pkg::CMD_HOST_WRITE, uartrq_pkg::CMD_TX_DONE,
                          TX_SLOTS + 2, TX_SLOTS + 2, 1'b0);
            end
            else
                add_word(uartrq_pkg::CMD_HOST_READ, 8'($urandom), 1'b1);
            while (pending_words.size() - added < PHASE_WORDS)
            begin
                kind = $urandom_range(0, 9);
                hold = ($urandom_range(0, 29) == 0);
                if (kind < 3)
                    add_burst(uartrq_pkg::CMD_RX_BYTE, uartrq_pkg::CMD_HOST_READ,
                              $urandom_range(1, RX_SLOTS + 4),
                              $urandom_range(1, RX_SLOTS + 4), hold);
                else if (kind < 6)
                    add_burst(uartrq_pkg::CMD_HOST_WRITE, uartrq_pkg::CMD_TX_DONE,
                              $urandom_range(1, TX_SLOTS + 4),
                              $urandom_range(1, TX_SLOTS + 4), hold);
                else
                    for (int i = $urandom_range(5, 40); i > 0; i--)
                        add_word(uartrq_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom),
                                 hold && i == 1);
            end
            while (pending_words.size() != 0)
                @(posedge clk);
        end

        // Let the last words come back, then watch for stray strobes.
        while (start || outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (awaited_status.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_status.size()));

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- uart_rx_tx_ring_queues.f -----
src/uartrq_pkg.sv
src/uartrq_ram.sv
src/uartrq_ctrl.sv
src/uartrq_dp.sv
src/uart_rx_tx_ring_queues.sv
sim/tb_uart_rx_tx_ring_queues.sv
